### hdl/mdt_pkg.sv
package mdt_pkg;

    localparam int MAX_RESULTS = 5;
    localparam int CNT_W       = 3;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_HASH      = 8'h23;
    localparam logic [7:0] CH_COLON     = 8'h3A;
    localparam logic [7:0] CH_SPACE     = 8'h20;
    localparam logic [7:0] CH_TAB       = 8'h09;
    localparam logic [7:0] CH_DOLLAR    = 8'h24;
    localparam logic [7:0] CH_NEWLINE   = 8'h0A;
    localparam logic [7:0] CH_SLASH     = 8'h2F;
    localparam logic [7:0] CH_CR        = 8'h0D;

    typedef enum logic [1:0] {
        KIND_BYTE      = 2'd0,
        KIND_TOKEN_END = 2'd1,
        KIND_COLON     = 2'd2,
        KIND_ENTRY_END = 2'd3
    } kind_t;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       end_of_text;
    } in_item_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] char_out;
        logic       last_of_run;
    } out_item_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] char_out;
    } result_t;

    // all results caused by one input item
    typedef struct packed {
        result_t [MAX_RESULTS-1:0] res;
        logic [CNT_W-1:0]          cnt;
    } bundle_t;

    typedef struct packed {
        logic       in_token;
        logic [1:0] len_class;
        logic       first_ws;
        logic       last_nonempty;
    } tok_state_t;

endpackage

### hdl/mdt_front.sv
module mdt_front
    import mdt_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  in_item_t item,
    input  logic     q_full,
    output logic     q_push,
    output bundle_t  q_bundle
);

    typedef struct packed {
        tok_state_t       st;
        result_t [1:0]    res;
        logic [1:0]       cnt;
        logic             used;
    } proc_res_t;

    function automatic logic is_ws(logic [7:0] c);
        return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
    endfunction

    function automatic proc_res_t emit(proc_res_t r, kind_t k, logic [7:0] ch);
        proc_res_t o;
        o = r;
        o.res[o.cnt[0]].kind     = k;
        o.res[o.cnt[0]].char_out = (k == KIND_BYTE) ? ch : 8'd0;
        o.cnt = o.cnt + 2'd1;
        return o;
    endfunction

    // ordinary byte inside a token, with escape handling
    function automatic proc_res_t body(proc_res_t r, logic [7:0] c, logic [7:0] la,
                                       logic has_la);
        proc_res_t  o;
        logic [7:0] ch;
        o  = r;
        ch = c;
        if (has_la)
        begin
            if (c == CH_BACKSLASH && (la == CH_BACKSLASH || la == CH_HASH ||
                la == CH_COLON || la == CH_SPACE || la == CH_TAB))
            begin
                ch     = la;
                o.used = 1'b1;
            end
            else if (c == CH_DOLLAR && la == CH_DOLLAR)
            begin
                o.used = 1'b1;
            end
        end
        if (o.st.len_class == 2'd0)
            o.st.first_ws = is_ws(ch);
        o = emit(o, KIND_BYTE, ch);
        if (o.st.len_class != 2'd2)
            o.st.len_class = o.st.len_class + 2'd1;
        return o;
    endfunction

    function automatic proc_res_t proc_byte(tok_state_t s, logic [7:0] c, logic [7:0] la,
                                            logic has_la);
        proc_res_t o;
        logic      bs_nl;
        logic      done;
        o      = '0;
        o.st   = s;
        done   = 1'b0;
        bs_nl  = (c == CH_BACKSLASH) && has_la && (la == CH_NEWLINE);
        if (s.in_token)
        begin
            if (c == CH_COLON && s.len_class == 2'd1 && !s.first_ws && has_la &&
                (la == CH_SLASH || la == CH_BACKSLASH))
            begin
                // drive letter: colon stays in the token
                o    = body(o, CH_COLON, 8'd0, 1'b0);
                done = 1'b1;
            end
            else if (c == CH_COLON || is_ws(c) || bs_nl)
            begin
                o = emit(o, KIND_TOKEN_END, 8'd0);
                o.st.in_token      = 1'b0;
                o.st.last_nonempty = 1'b1;
            end
            else
            begin
                o    = body(o, c, la, has_la);
                done = 1'b1;
            end
        end
        if (!done)
        begin
            if (c == CH_NEWLINE)
            begin
                if (o.st.last_nonempty)
                    o = emit(o, KIND_ENTRY_END, 8'd0);
                o.st.last_nonempty = 1'b0;
            end
            else if (is_ws(c))
            begin
                o.used = 1'b0;
            end
            else if (c == CH_COLON)
            begin
                o = emit(o, KIND_COLON, 8'd0);
                o.st.last_nonempty = 1'b1;
            end
            else if (bs_nl)
            begin
                o.used = 1'b1;
            end
            else
            begin
                o.st.in_token  = 1'b1;
                o.st.len_class = 2'd0;
                o.st.first_ws  = 1'b0;
                o = body(o, c, la, has_la);
            end
        end
        return o;
    endfunction

    logic [7:0] held_byte_reg, held_byte_next;
    logic       held_valid_reg, held_valid_next;
    logic       consume_reg, consume_next;
    tok_state_t tok_reg, tok_next;

    logic       accept;
    bundle_t    bundle;

    assign accept = push && !q_full;

    always_comb
    begin
        proc_res_t        p1;
        proc_res_t        p2;
        tok_state_t       st;
        logic             used;
        logic [CNT_W-1:0] pos;
        p1   = '0;
        p2   = '0;
        st   = tok_reg;
        used = 1'b0;
        pos  = '0;
        bundle = '0;

        if (held_valid_reg && !consume_reg)
        begin
            p1   = proc_byte(st, held_byte_reg, item.text_byte, 1'b1);
            st   = p1.st;
            used = p1.used;
            if (p1.cnt != 2'd0)
            begin
                bundle.res[pos] = p1.res[0];
                pos = pos + 3'd1;
            end
            if (p1.cnt == 2'd2)
            begin
                bundle.res[pos] = p1.res[1];
                pos = pos + 3'd1;
            end
        end

        held_byte_next  = held_byte_reg;
        held_valid_next = held_valid_reg;
        consume_next    = consume_reg;
        tok_next        = tok_reg;

        if (!item.end_of_text)
        begin
            held_byte_next  = item.text_byte;
            held_valid_next = 1'b1;
            consume_next    = used;
            tok_next        = st;
        end
        else
        begin
            // final byte: no lookahead, then close everything out
            if (!used)
            begin
                p2 = proc_byte(st, item.text_byte, 8'd0, 1'b0);
                st = p2.st;
                if (p2.cnt != 2'd0)
                begin
                    bundle.res[pos] = p2.res[0];
                    pos = pos + 3'd1;
                end
                if (p2.cnt == 2'd2)
                begin
                    bundle.res[pos] = p2.res[1];
                    pos = pos + 3'd1;
                end
            end
            if (st.in_token)
            begin
                bundle.res[pos] = '{kind: KIND_TOKEN_END, char_out: 8'd0};
                pos = pos + 3'd1;
                st.in_token      = 1'b0;
                st.last_nonempty = 1'b1;
            end
            if (st.last_nonempty)
            begin
                bundle.res[pos] = '{kind: KIND_ENTRY_END, char_out: 8'd0};
                pos = pos + 3'd1;
            end
            held_byte_next  = 8'd0;
            held_valid_next = 1'b0;
            consume_next    = 1'b0;
            tok_next        = '0;
        end
        bundle.cnt = pos;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_byte_reg  <= 8'd0;
            held_valid_reg <= 1'b0;
            consume_reg    <= 1'b0;
            tok_reg        <= '0;
        end
        else if (accept)
        begin
            held_byte_reg  <= held_byte_next;
            held_valid_reg <= held_valid_next;
            consume_reg    <= consume_next;
            tok_reg        <= tok_next;
        end
    end

    // items that cause nothing never enter the queue
    assign q_push   = accept && (bundle.cnt != '0);
    assign q_bundle = bundle;

endmodule

### hdl/mdt_queue.sv
module mdt_queue
    import mdt_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    wr_en,
    input  bundle_t wr_data,
    output logic    full,
    input  logic    rd_en,
    output bundle_t rd_data,
    output logic    empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_Q = $clog2(DEPTH + 1);

    bundle_t            mem_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_Q-1:0]   count_reg, count_next;
    logic               do_wr, do_rd;

    assign full    = (count_reg == CNT_Q'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_rd)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (do_wr && !do_rd)
            count_next = count_reg + 1'b1;
        else if (do_rd && !do_wr)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
            mem_reg[wr_ptr_reg] <= wr_data;
    end

endmodule

### hdl/mdt_back.sv
module mdt_back
    import mdt_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  bundle_t   q_head,
    input  logic      q_empty,
    output logic      q_pop,
    output logic      empty,
    input  logic      pop,
    output out_item_t result
);

    logic [CNT_W-1:0] idx_reg, idx_next;
    logic             is_last;
    logic             fire;

    assign is_last = (idx_reg == (q_head.cnt - 3'd1));
    assign fire    = pop && !q_empty;
    assign empty   = q_empty;
    assign q_pop   = fire && is_last;

    assign result.kind        = q_head.res[idx_reg].kind;
    assign result.char_out    = q_head.res[idx_reg].char_out;
    assign result.last_of_run = is_last;

    always_comb
    begin
        idx_next = idx_reg;
        if (fire)
            idx_next = is_last ? '0 : idx_reg + 3'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            idx_reg <= '0;
        else
            idx_reg <= idx_next;
    end

endmodule

### hdl/makefile_dependency_tokenizer.sv
// dependency text tokenizer
//
// input queue side: item carries one text byte and an end_of_text flag; the
// item is taken on a clock edge with push high and full low
// result queue side: while empty is low the oldest result sits on result;
// it is taken on a clock edge with pop high
//
// one byte is held back as lookahead, so the first byte of a longer text gives
// no result; later bytes give zero to two results, the final byte up to five
// the front stage classifies an item combinationally and writes all of its
// results as one entry into a small queue; the back stage hands them out
// one per cycle while pop is high; a new entry is registered in the queue first
// throughput: one item per cycle while pop stays high and each item gives at
// most one result; otherwise bounded by the single result port, one result per cycle
// a stalled receiver fills the queue, then full rises and holds the sender
// reset clears held byte, token state and the queue
module makefile_dependency_tokenizer
    import mdt_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    output logic      full,
    input  in_item_t  item,
    output logic      empty,
    input  logic      pop,
    output out_item_t result
);

    // front to queue
    logic    q_push;
    bundle_t q_wr_data;
    // queue to back
    bundle_t q_head;
    logic    q_empty;
    logic    q_pop;

    mdt_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .item     (item),
        .q_full   (full),
        .q_push   (q_push),
        .q_bundle (q_wr_data)
    );

    // result bundles wait here so the two sides stall independently
    mdt_queue #(
        .DEPTH (DEPTH)
    ) u_queue
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (q_push),
        .wr_data (q_wr_data),
        .full    (full),
        .rd_en   (q_pop),
        .rd_data (q_head),
        .empty   (q_empty)
    );

    mdt_back u_back
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_head  (q_head),
        .q_empty (q_empty),
        .q_pop   (q_pop),
        .empty   (empty),
        .pop     (pop),
        .result  (result)
    );

endmodule

### test/tb_makefile_dependency_tokenizer.sv
`timescale 1ns / 100ps

module tb_makefile_dependency_tokenizer;
    import mdt_pkg::*;

    // generous bound: 450 items, up to five results each, receiver idle 80%
    localparam int unsigned CYCLE_LIMIT = 200000;
    // cycles to wait after the last expected result for any stray output
    localparam int DRAIN_CYCLES = 20;

    // scoreboard: tracks tokenizer state and holds the results still owed
    class tokenizer_scoreboard;
        // byte waiting for its lookahead
        logic [7:0] held_byte;
        bit         held_ok;
        // held byte was already eaten as the second half of an escape
        bit         skip_held;
        // open token and what we know about it
        bit         tok_open;
        bit [1:0]   tok_len;
        bit         tok_first_ws;
        // a token end or colon came since the last newline, so an entry end is due
        bit         sep_seen;
        out_item_t  step_q[$];
        out_item_t  owed_q[$];
        int         errors;

        function new();
            clear_text();
            errors = 0;
        endfunction

        function void clear_text();
            held_byte    = 8'h00;
            held_ok      = 1'b0;
            skip_held    = 1'b0;
            tok_open     = 1'b0;
            tok_len      = 2'd0;
            tok_first_ws = 1'b0;
            sep_seen     = 1'b0;
        endfunction

        function bit is_space(logic [7:0] c);
            return c == CH_SPACE || (c >= 8'd9 && c <= 8'd13);
        endfunction

        function void emit(kind_t k, logic [7:0] ch);
            out_item_t r;
            if (step_q.size() >= MAX_RESULTS)
                return;
            r.kind        = k;
            r.char_out    = (k == KIND_BYTE) ? ch : 8'h00;
            r.last_of_run = 1'b0;
            step_q = {step_q, r};
        endfunction

        function void add_char(logic [7:0] ch);
            if (tok_len == 2'd0)
                tok_first_ws = is_space(ch);
            emit(KIND_BYTE, ch);
            if (tok_len < 2'd2)
                tok_len++;
        endfunction

        // ordinary byte inside a token; returns 1 when the lookahead is eaten
        function bit token_char(logic [7:0] c, logic [7:0] la, bit has_la);
            logic [7:0] ch;
            bit         eaten;
            ch    = c;
            eaten = 1'b0;
            if (has_la)
            begin
                if (c == CH_BACKSLASH && (la == CH_BACKSLASH || la == CH_HASH ||
                    la == CH_COLON || la == CH_SPACE || la == CH_TAB))
                begin
                    ch    = la;
                    eaten = 1'b1;
                end
                else if (c == CH_DOLLAR && la == CH_DOLLAR)
                begin
                    eaten = 1'b1;
                end
            end
            add_char(ch);
            return eaten;
        endfunction

        // judge byte c against its lookahead; returns 1 when la is eaten
        function bit split_byte(logic [7:0] c, logic [7:0] la, bit has_la);
            bit cont;
            cont = (c == CH_BACKSLASH) && has_la && (la == CH_NEWLINE);
            if (tok_open)
            begin
                // drive letter colon stays inside the token
                if (c == CH_COLON && tok_len == 2'd1 && !tok_first_ws && has_la &&
                    (la == CH_SLASH || la == CH_BACKSLASH))
                begin
                    add_char(CH_COLON);
                    return 1'b0;
                end
                if (c == CH_COLON || is_space(c) || cont)
                begin
                    emit(KIND_TOKEN_END, 8'h00);
                    tok_open = 1'b0;
                    sep_seen = 1'b1;
                end
                else
                begin
                    return token_char(c, la, has_la);
                end
            end
            if (c == CH_NEWLINE)
            begin
                if (sep_seen)
                    emit(KIND_ENTRY_END, 8'h00);
                sep_seen = 1'b0;
                return 1'b0;
            end
            if (is_space(c))
                return 1'b0;
            if (c == CH_COLON)
            begin
                emit(KIND_COLON, 8'h00);
                sep_seen = 1'b1;
                return 1'b0;
            end
            if (cont)
                return 1'b1;
            tok_open     = 1'b1;
            tok_len      = 2'd0;
            tok_first_ws = 1'b0;
            return token_char(c, la, has_la);
        endfunction

        // accepted input item: work out the results it causes
        function void note_input(in_item_t it);
            bit eaten;
            eaten = 1'b0;
            step_q.delete();
            if (held_ok && !skip_held)
                eaten = split_byte(held_byte, it.text_byte, 1'b1);
            if (!it.end_of_text)
            begin
                held_byte = it.text_byte;
                held_ok   = 1'b1;
                skip_held = eaten;
            end
            else
            begin
                // final byte has no lookahead, then close everything
                if (!eaten)
                    void'(split_byte(it.text_byte, 8'h00, 1'b0));
                if (tok_open)
                begin
                    emit(KIND_TOKEN_END, 8'h00);
                    tok_open = 1'b0;
                    sep_seen = 1'b1;
                end
                if (sep_seen)
                    emit(KIND_ENTRY_END, 8'h00);
                clear_text();
            end
            if (step_q.size() > 0)
                step_q[step_q.size() - 1].last_of_run = 1'b1;
            owed_q = {owed_q, step_q};
        endfunction

        function void check_result(out_item_t got);
            out_item_t want;
            if (owed_q.size() == 0)
            begin
                $error("unexpected result: kind %0d char %02h last %0b",
                       got.kind, got.char_out, got.last_of_run);
                errors++;
                return;
            end
            want = owed_q.pop_front();
            if (got.kind !== want.kind)
            begin
                $error("kind: expected %0d, got %0d", want.kind, got.kind);
                errors++;
            end
            if (got.char_out !== want.char_out)
            begin
                $error("char_out: expected %02h, got %02h", want.char_out, got.char_out);
                errors++;
            end
            if (got.last_of_run !== want.last_of_run)
            begin
                $error("last_of_run: expected %0b, got %0b",
                       want.last_of_run, got.last_of_run);
                errors++;
            end
        endfunction

        function int pending();
            return owed_q.size();
        endfunction
    endclass

    logic       clk   = 1'b0;
    logic       rst_n = 1'b0;
    logic       push  = 1'b0;
    logic       pop   = 1'b0;
    in_item_t   item  = '0;
    logic       full;
    logic       empty;
    out_item_t  result;

    int unsigned cycles = 0;
    // idle chances in percent for each side, changed per phase
    int send_idle_pct = 17;
    int recv_idle_pct = 80;
    int items_sent    = 0;

    tokenizer_scoreboard sb = new();

    makefile_dependency_tokenizer dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .full   (full),
        .item   (item),
        .empty  (empty),
        .pop    (pop),
        .result (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    // receiver: check the result taken at this edge, then pick next pop
    always @(posedge clk)
    begin
        if (rst_n && pop && !empty)
            sb.check_result(result);
        pop <= ($urandom_range(99) >= recv_idle_pct);
    end

    // one item, with random idle cycles in front; push stays high on return
    task automatic send_item(logic [7:0] b, logic eot);
        while ($urandom_range(99) < send_idle_pct)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push <= 1'b1;
        item <= '{text_byte: b, end_of_text: eot};
        do
            @(posedge clk);
        while (full);
        sb.note_input('{text_byte: b, end_of_text: eot});
        items_sent++;
    endtask

    // whole text, end flag on its final byte
    task automatic send_text(string s);
        int i;
        for (i = 0; i < s.len(); i++)
            send_item(s[i], i == s.len() - 1);
    endtask

    // random text built from pieces that hit the tokenizer's corners:
    // drive paths, escapes, doubled dollars, continuations, whitespace,
    // colons, newlines, and plain noise bytes
    task automatic send_random_text();
        logic [7:0] txt[$];
        int         pieces;
        int         i;
        pieces = $urandom_range(1, 12);
        for (i = 0; i < pieces; i++)
        begin
            case ($urandom_range(8))
                0: txt = {txt, 8'h61 + 8'($urandom_range(25))};
                1:
                begin
                    // drive letter path prefix
                    txt = {txt, 8'h41 + 8'($urandom_range(25))};
                    txt = {txt, CH_COLON};
                    txt = {txt, $urandom_range(1) ? CH_SLASH : CH_BACKSLASH};
                end
                2:
                begin
                    txt = {txt, CH_BACKSLASH};
                    case ($urandom_range(4))
                        0: txt = {txt, CH_BACKSLASH};
                        1: txt = {txt, CH_HASH};
                        2: txt = {txt, CH_COLON};
                        3: txt = {txt, CH_SPACE};
                        default: txt = {txt, CH_TAB};
                    endcase
                end
                3:
                begin
                    txt = {txt, CH_DOLLAR};
                    txt = {txt, CH_DOLLAR};
                end
                4:
                begin
                    // line continuation
                    txt = {txt, CH_BACKSLASH};
                    txt = {txt, CH_NEWLINE};
                end
                5:
                begin
                    case ($urandom_range(4))
                        0: txt = {txt, CH_SPACE};
                        1: txt = {txt, CH_TAB};
                        2: txt = {txt, CH_CR};
                        3: txt = {txt, 8'h0B};
                        default: txt = {txt, 8'h0C};
                    endcase
                end
                6: txt = {txt, CH_COLON};
                7: txt = {txt, CH_NEWLINE};
                default: txt = {txt, 8'($urandom_range(255))};
            endcase
        end
        for (i = 0; i < txt.size(); i++)
            send_item(txt[i], i == txt.size() - 1);
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed texts
        // drive path, plain token, colon between tokens
        send_text("C:\\d e:f");
        // escaped space, continuation, doubled dollar, colon, tab at the end
        send_text("\\ \\\n$$:\t");
        // extreme byte values
        send_item(8'h00, 1'b0);
        send_item(8'hFF, 1'b0);
        send_item(CH_NEWLINE, 1'b1);
        // text of a single byte
        send_item(8'hFF, 1'b1);
        // backslash on the final byte has no lookahead
        send_text("x\\");

        // sender idles rarely, receiver mostly stalls
        while (items_sent < 150)
            send_random_text();

        // sender mostly idle, receiver rarely stalls
        send_idle_pct = 80;
        recv_idle_pct = 17;
        while (items_sent < 300)
            send_random_text();

        // full rate on both sides
        send_idle_pct = 0;
        recv_idle_pct = 0;
        while (items_sent < 450)
            send_random_text();
        push <= 1'b0;

        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (sb.errors == 0 && sb.pending() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
